### hw/rtl/bfpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpn_pkg
// Shared types and constants for the quadratic Bezier foot point finder.
// ----------------------------------------------------------------------------
package bfpn_pkg;

    // default sizing
    localparam int SAMPLES_DEF  = 100;
    localparam int MAX_ITER_DEF = 20;

    // fixed point formats
    localparam int PW       = 17;     // parameter width, Q1.16
    localparam int ONE_Q16  = 65536;
    localparam int WIN_HALF = 6554;   // 0.1 in Q1.16
    localparam int STEP_SAT = 131072;

    // configuration register map
    typedef enum logic [2:0] {
        REG_CTRL0_X = 3'd0,
        REG_CTRL0_Y = 3'd1,
        REG_CTRL1_X = 3'd2,
        REG_CTRL1_Y = 3'd3,
        REG_CTRL2_X = 3'd4,
        REG_CTRL2_Y = 3'd5
    } cfg_reg_t;

    // input beat
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               first_of_set;
    } point_t;

    // output beat
    typedef struct packed {
        logic [16:0] refined_param;
        logic [6:0]  coarse_index;
        logic [4:0]  steps_used;
        logic        flat_curvature;
    } result_t;

endpackage

### hw/rtl/bfpn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bfpn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bezier_foot_point_newton.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_foot_point_newton
// Projects points onto a configured quadratic Bezier curve: coarse nearest
// sample search over a sample RAM, then Newton refinement of the parameter.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*    : write the six control point coordinates (index 0..5) while idle.
//   point    : one beat per point; first_of_set rebuilds the sample table from
//              the current control points and restarts the search at sample 0.
//   result   : one beat per point, held in an output register until taken.
// Timing: one point at a time. A rebuild computes each sample from the current
//   control points into the sample RAM. The scan reads the sample RAM once per
//   cycle from the search start to the last sample, then drains its pipeline.
//   Each Newton step uses the shared 36x36 multiplier (7 curve products, 6 dot
//   products) and the restoring divider; up to MAX_ITER steps.
// The next point is accepted once the current one has entered the output
// register; if the receiver stalls, the block finishes that next point and
// then waits for the output register to free up.
// Reset clears the control points and the search start; the sample table is
// not cleared and must be built by a first_of_set beat.
// ----------------------------------------------------------------------------
module bezier_foot_point_newton #(
    parameter int SAMPLES  = bfpn_pkg::SAMPLES_DEF,
    parameter int MAX_ITER = bfpn_pkg::MAX_ITER_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_ready,
    input  bfpn_pkg::point_t  point,
    output logic              result_valid,
    input  logic              result_ready,
    output bfpn_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int PW    = bfpn_pkg::PW;
    localparam int IW    = $clog2(SAMPLES);
    localparam int IW1   = IW + 1;
    localparam int SW    = $clog2(MAX_ITER + 1);
    localparam int N     = SAMPLES - 1;
    localparam int PSTEP = 65536 / N;
    localparam int PREM  = 65536 % N;
    localparam int RINIT = N / 2;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_EVAL     = 11'b00000000010,
        S_CURVE    = 11'b00000000100,
        S_SCAN     = 11'b00000001000,
        S_SCAN_END = 11'b00000010000,
        S_NORM     = 11'b00000100000,
        S_FMUL     = 11'b00001000000,
        S_DIVSET   = 11'b00010000000,
        S_DIV      = 11'b00100000000,
        S_UPDATE   = 11'b01000000000,
        S_FINISH   = 11'b10000000000
    } state_t;

    // advance the sample parameter round(i*65536/N) to index i+1
    function automatic logic [PW+IW-1:0] param_adv(input logic [PW-1:0] q,
                                                  input logic [IW-1:0] r);
        logic [IW1-1:0] rs;
        logic [PW-1:0]  qn;
        begin
            rs = {1'b0, r} + IW1'(PREM);
            qn = q + PW'(PSTEP);
            if (rs >= IW1'(N))
            begin
                rs = rs - IW1'(N);
                qn = qn + PW'(1);
            end
            return {qn, rs[IW-1:0]};
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        begin
            if (v > 41'sd2147483647)
                return 32'sh7FFFFFFF;
            else if (v < -41'sd2147483648)
                return 32'sh80000000;
            else
                return 32'(v);
        end
    endfunction

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    state_t state_reg, state_next;
    logic signed [31:0] c0x_reg, c0y_reg, c1x_reg, c1y_reg, c2x_reg, c2y_reg;
    logic signed [31:0] c0x_next, c0y_next, c1x_next, c1y_next, c2x_next, c2y_next;
    logic              result_valid_reg, result_valid_next;
    bfpn_pkg::result_t result_reg, result_next;
    logic [IW-1:0]     search_start_reg, search_start_next;
    logic [PW-1:0]     start_q_reg, start_q_next;
    logic [IW-1:0]     start_r_reg, start_r_next;
    logic              building_reg, building_next;
    logic [2:0]        mstep_reg, mstep_next;
    logic              iss_active_reg, iss_active_next;
    logic              v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic [SW-1:0]     steps_reg, steps_next;
    logic              flat_reg, flat_next;

    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic [PW-1:0]      t_reg, t_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [PW-1:0]      acc_q_reg, acc_q_next;
    logic [IW-1:0]      acc_r_reg, acc_r_next;
    logic               first_reg, first_next;
    logic signed [71:0] prod_reg;
    logic signed [53:0] pr_reg [7];
    logic signed [53:0] pr_next [7];
    logic signed [39:0] vv_reg [6];
    logic signed [39:0] vv_next [6];
    logic signed [30:0] vs_reg [6];
    logic signed [30:0] vs_next [6];
    logic signed [63:0] f1_reg, f1_next, f2_reg, f2_next;
    logic [63:0]        rem_reg, rem_next, den_reg, den_next;
    logic [17:0]        q_reg, q_next;
    logic               neg_reg, neg_next;
    logic [4:0]         dcnt_reg, dcnt_next;
    logic [PW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [IW-1:0]      idx1_reg, idx1_next, idx2_reg, idx2_next, idx3_reg, idx3_next;
    logic [PW-1:0]      q1_reg, q1_next, q2_reg, q2_next, q3_reg, q3_next;
    logic [IW-1:0]      r1_reg, r1_next, r2_reg, r2_next, r3_reg, r3_next;
    logic               fs1_reg, fs1_next, fs2_reg, fs2_next, fs3_reg, fs3_next;
    logic [31:0]        dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic [63:0]        sqx3_reg, sqx3_next, sqy3_reg, sqy3_next;
    logic [64:0]        best_d_reg, best_d_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    logic [PW-1:0]      best_q_reg, best_q_next;
    logic [IW-1:0]      best_r_reg, best_r_next;

    // ------------------------------------------------------------------------
    // sample RAM: {y, x} per sample
    // ------------------------------------------------------------------------
    logic        ram_we;
    logic [63:0] ram_wdata, ram_rdata;

    bfpn_ram #(
        .WIDTH (64),
        .DEPTH (SAMPLES)
    ) u_samples (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // curve coefficients a = c1-c0, b = c0-2c1+c2
    // ------------------------------------------------------------------------
    logic signed [34:0] ax, ay, bx, by;
    assign ax = 35'(c1x_reg) - 35'(c0x_reg);
    assign ay = 35'(c1y_reg) - 35'(c0y_reg);
    assign bx = 35'(c0x_reg) + 35'(c2x_reg) - (35'(c1x_reg) <<< 1);
    assign by = 35'(c0y_reg) + 35'(c2y_reg) - (35'(c1y_reg) <<< 1);

    // round(t*t / 2^16)
    logic signed [53:0] tt_rnd;
    logic [17:0]        t2;
    assign tt_rnd = pr_reg[0] + 54'sd32768;
    assign t2     = 18'(tt_rnd >>> 16);

    // ------------------------------------------------------------------------
    // shared multiplier operand select
    // ------------------------------------------------------------------------
    logic signed [35:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_EVAL)
        begin
            case (mstep_reg)
                3'd0: begin mul_a = 36'(t_reg); mul_b = 36'(t_reg); end
                3'd1: begin mul_a = 36'(t_reg); mul_b = 36'(ax);    end
                3'd2: begin mul_a = 36'(t_reg); mul_b = 36'(ay);    end
                3'd3: begin mul_a = 36'(t_reg); mul_b = 36'(bx);    end
                3'd4: begin mul_a = 36'(t_reg); mul_b = 36'(by);    end
                3'd5: begin mul_a = 36'(t2);    mul_b = 36'(bx);    end
                3'd6: begin mul_a = 36'(t2);    mul_b = 36'(by);    end
                default: ;
            endcase
        end
        else if (state_reg == S_FMUL)
        begin
            case (mstep_reg)
                3'd0: begin mul_a = 36'(vs_reg[0]); mul_b = 36'(vs_reg[2]); end
                3'd1: begin mul_a = 36'(vs_reg[1]); mul_b = 36'(vs_reg[3]); end
                3'd2: begin mul_a = 36'(vs_reg[2]); mul_b = 36'(vs_reg[2]); end
                3'd3: begin mul_a = 36'(vs_reg[3]); mul_b = 36'(vs_reg[3]); end
                3'd4: begin mul_a = 36'(vs_reg[0]); mul_b = 36'(vs_reg[4]); end
                3'd5: begin mul_a = 36'(vs_reg[1]); mul_b = 36'(vs_reg[5]); end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // curve point and slope from the captured products
    // ------------------------------------------------------------------------
    logic signed [55:0] cxs, cys, sxs, sys;
    logic signed [31:0] cur_x, cur_y;
    logic signed [39:0] sl_x, sl_y;
    assign cxs   = (56'(pr_reg[1]) <<< 1) + 56'(pr_reg[5]) + 56'sd32768;
    assign cys   = (56'(pr_reg[2]) <<< 1) + 56'(pr_reg[6]) + 56'sd32768;
    assign cur_x = sat32(41'(c0x_reg) + 41'(cxs >>> 16));
    assign cur_y = sat32(41'(c0y_reg) + 41'(cys >>> 16));
    assign sxs   = (56'(pr_reg[3]) <<< 1) + 56'sd32768;
    assign sys   = (56'(pr_reg[4]) <<< 1) + 56'sd32768;
    assign sl_x  = (40'(ax) <<< 1) + 40'(sxs >>> 16);
    assign sl_y  = (40'(ay) <<< 1) + 40'(sys >>> 16);

    // ------------------------------------------------------------------------
    // normalize shift: smallest k with every magnitude >> k below 2^30
    // ------------------------------------------------------------------------
    logic [39:0] norm_or;
    logic [3:0]  norm_k;
    always_comb
    begin
        norm_or = '0;
        for (int j = 0; j < 6; j++)
        begin
            norm_or = norm_or | (vv_reg[j][39] ? 40'(-vv_reg[j]) : 40'(vv_reg[j]));
        end
        norm_k = 4'd10;
        for (int kk = 9; kk >= 0; kk--)
        begin
            if ((norm_or >> (30 + kk)) == 40'd0)
                norm_k = 4'(kk);
        end
    end

    // ------------------------------------------------------------------------
    // scan datapath pieces
    // ------------------------------------------------------------------------
    logic signed [32:0] scan_dx, scan_dy;
    logic [32:0]        scan_mx, scan_my;
    logic [64:0]        scan_d;
    assign scan_dx = 33'($signed(ram_rdata[31:0])) - 33'(px_reg);
    assign scan_dy = 33'($signed(ram_rdata[63:32])) - 33'(py_reg);
    assign scan_mx = scan_dx[32] ? 33'(-scan_dx) : 33'(scan_dx);
    assign scan_my = scan_dy[32] ? 33'(-scan_dy) : 33'(scan_dy);
    assign scan_d  = 65'(sqx3_reg) + 65'(sqy3_reg);

    // divider and update helpers
    logic [64:0]        div_sh;
    logic [63:0]        f1_mag, f2_mag;
    logic signed [19:0] upd_step, upd_tn, upd_tc;
    logic [PW+IW-1:0]   adv_acc;
    logic [17:0]        win_lo;
    logic [17:0]        win_hi;
    assign div_sh   = {rem_reg, 1'b0};
    assign f1_mag   = f1_reg[63] ? 64'(-f1_reg) : 64'(f1_reg);
    assign f2_mag   = f2_reg[63] ? 64'(-f2_reg) : 64'(f2_reg);
    assign upd_step = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign upd_tn   = $signed({3'b000, t_reg}) - upd_step;
    assign upd_tc   = (upd_tn < $signed({3'b000, lo_reg})) ? $signed({3'b000, lo_reg}) :
                      (upd_tn > $signed({3'b000, hi_reg})) ? $signed({3'b000, hi_reg}) :
                      upd_tn;
    assign adv_acc  = param_adv(acc_q_reg, acc_r_reg);
    assign win_lo   = {1'b0, best_q_reg} - 18'(bfpn_pkg::WIN_HALF);
    assign win_hi   = {1'b0, best_q_reg} + 18'(bfpn_pkg::WIN_HALF);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        c0x_next          = c0x_reg;
        c0y_next          = c0y_reg;
        c1x_next          = c1x_reg;
        c1y_next          = c1y_reg;
        c2x_next          = c2x_reg;
        c2y_next          = c2y_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        search_start_next = search_start_reg;
        start_q_next      = start_q_reg;
        start_r_next      = start_r_reg;
        building_next     = building_reg;
        mstep_next        = mstep_reg;
        iss_active_next   = iss_active_reg;
        steps_next        = steps_reg;
        flat_next         = flat_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        t_next            = t_reg;
        idx_next          = idx_reg;
        acc_q_next        = acc_q_reg;
        acc_r_next        = acc_r_reg;
        first_next        = first_reg;
        for (int j = 0; j < 7; j++)
            pr_next[j] = pr_reg[j];
        for (int j = 0; j < 6; j++)
        begin
            vv_next[j] = vv_reg[j];
            vs_next[j] = vs_reg[j];
        end
        f1_next       = f1_reg;
        f2_next       = f2_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        q_next        = q_reg;
        neg_next      = neg_reg;
        dcnt_next     = dcnt_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        best_d_next   = best_d_reg;
        best_idx_next = best_idx_reg;
        best_q_next   = best_q_reg;
        best_r_next   = best_r_reg;
        ram_we        = 1'b0;
        ram_wdata     = {cur_y, cur_x};

        // scan pipeline: read, distance, square, compare
        v1_next   = (state_reg == S_SCAN) && iss_active_reg;
        idx1_next = idx_reg;
        q1_next   = acc_q_reg;
        r1_next   = acc_r_reg;
        fs1_next  = first_reg;
        v2_next   = v1_reg;
        idx2_next = idx1_reg;
        q2_next   = q1_reg;
        r2_next   = r1_reg;
        fs2_next  = fs1_reg;
        dx2_next  = scan_mx[32:1];
        dy2_next  = scan_my[32:1];
        v3_next   = v2_reg;
        idx3_next = idx2_reg;
        q3_next   = q2_reg;
        r3_next   = r2_reg;
        fs3_next  = fs2_reg;
        sqx3_next = dx2_reg * dx2_reg;
        sqy3_next = dy2_reg * dy2_reg;
        if (v3_reg && (fs3_reg || scan_d < best_d_reg))
        begin
            best_d_next   = scan_d;
            best_idx_next = idx3_reg;
            best_q_next   = q3_reg;
            best_r_next   = r3_reg;
        end

        // configuration writes
        if (cfg_valid)
        begin
            case (bfpn_pkg::cfg_reg_t'(cfg_index))
                bfpn_pkg::REG_CTRL0_X: c0x_next = $signed(cfg_data);
                bfpn_pkg::REG_CTRL0_Y: c0y_next = $signed(cfg_data);
                bfpn_pkg::REG_CTRL1_X: c1x_next = $signed(cfg_data);
                bfpn_pkg::REG_CTRL1_Y: c1y_next = $signed(cfg_data);
                bfpn_pkg::REG_CTRL2_X: c2x_next = $signed(cfg_data);
                bfpn_pkg::REG_CTRL2_Y: c2y_next = $signed(cfg_data);
                default: ;
            endcase
        end

        // output register drains
        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    px_next = point.point_x;
                    py_next = point.point_y;
                    if (point.first_of_set)
                    begin
                        building_next = 1'b1;
                        idx_next      = '0;
                        acc_q_next    = '0;
                        acc_r_next    = IW'(RINIT);
                        t_next        = '0;
                        mstep_next    = '0;
                        state_next    = S_EVAL;
                    end
                    else
                    begin
                        idx_next        = search_start_reg;
                        acc_q_next      = start_q_reg;
                        acc_r_next      = start_r_reg;
                        first_next      = 1'b1;
                        iss_active_next = 1'b1;
                        state_next      = S_SCAN;
                    end
                end
            end

            // seven products: t*t, t*a, t*b, round(t*t)*b
            S_EVAL:
            begin
                if (mstep_reg != 3'd0)
                    pr_next[mstep_reg - 3'd1] = 54'(prod_reg);
                if (mstep_reg == 3'd7)
                    state_next = S_CURVE;
                else
                    mstep_next = mstep_reg + 3'd1;
            end

            S_CURVE:
            begin
                if (building_reg)
                begin
                    ram_we = 1'b1;
                    if (idx_reg == IW'(N))
                    begin
                        building_next     = 1'b0;
                        search_start_next = '0;
                        start_q_next      = '0;
                        start_r_next      = IW'(RINIT);
                        idx_next          = '0;
                        acc_q_next        = '0;
                        acc_r_next        = IW'(RINIT);
                        first_next        = 1'b1;
                        iss_active_next   = 1'b1;
                        state_next        = S_SCAN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        acc_q_next = adv_acc[PW+IW-1:IW];
                        acc_r_next = adv_acc[IW-1:0];
                        t_next     = adv_acc[PW+IW-1:IW];
                        mstep_next = '0;
                        state_next = S_EVAL;
                    end
                end
                else
                begin
                    vv_next[0] = 40'(cur_x) - 40'(px_reg);
                    vv_next[1] = 40'(cur_y) - 40'(py_reg);
                    vv_next[2] = sl_x;
                    vv_next[3] = sl_y;
                    vv_next[4] = 40'(bx) <<< 1;
                    vv_next[5] = 40'(by) <<< 1;
                    state_next = S_NORM;
                end
            end

            // one sample read per cycle, then drain the pipeline
            S_SCAN:
            begin
                if (iss_active_reg)
                begin
                    first_next = 1'b0;
                    if (idx_reg == IW'(N))
                        iss_active_next = 1'b0;
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        acc_q_next = adv_acc[PW+IW-1:IW];
                        acc_r_next = adv_acc[IW-1:0];
                    end
                end
                else if (!v1_reg && !v2_reg && !v3_reg)
                    state_next = S_SCAN_END;
            end

            S_SCAN_END:
            begin
                search_start_next = best_idx_reg;
                start_q_next      = best_q_reg;
                start_r_next      = best_r_reg;
                t_next            = best_q_reg;
                lo_next           = win_lo[17] ? '0 : win_lo[PW-1:0];
                hi_next           = (win_hi > 18'(bfpn_pkg::ONE_Q16)) ?
                                    PW'(bfpn_pkg::ONE_Q16) : win_hi[PW-1:0];
                steps_next        = SW'(1);
                flat_next         = 1'b0;
                mstep_next        = '0;
                state_next        = S_EVAL;
            end

            S_NORM:
            begin
                for (int j = 0; j < 6; j++)
                    vs_next[j] = 31'(vv_reg[j] >>> norm_k);
                f1_next    = '0;
                f2_next    = '0;
                mstep_next = '0;
                state_next = S_FMUL;
            end

            // f1 = d.P1, f2 = P1.P1 + d.P2
            S_FMUL:
            begin
                if (mstep_reg == 3'd1 || mstep_reg == 3'd2)
                    f1_next = f1_reg + 64'(prod_reg);
                else if (mstep_reg != 3'd0)
                    f2_next = f2_reg + 64'(prod_reg);
                if (mstep_reg == 3'd6)
                    state_next = S_DIVSET;
                else
                    mstep_next = mstep_reg + 3'd1;
            end

            S_DIVSET:
            begin
                neg_next = f1_reg[63] ^ f2_reg[63];
                den_next = f2_mag;
                if (f2_reg == 64'sd0)
                begin
                    flat_next  = 1'b1;
                    state_next = S_FINISH;
                end
                else if ({1'b0, f1_mag} >= {f2_mag, 1'b0})
                begin
                    q_next     = 18'(bfpn_pkg::STEP_SAT);
                    state_next = S_UPDATE;
                end
                else
                begin
                    if (f1_mag >= f2_mag)
                    begin
                        q_next   = 18'd1;
                        rem_next = f1_mag - f2_mag;
                    end
                    else
                    begin
                        q_next   = 18'd0;
                        rem_next = f1_mag;
                    end
                    dcnt_next  = 5'd16;
                    state_next = S_DIV;
                end
            end

            // restoring division, one quotient bit per cycle
            S_DIV:
            begin
                if (div_sh >= {1'b0, den_reg})
                begin
                    rem_next = 64'(div_sh - {1'b0, den_reg});
                    q_next   = {q_reg[16:0], 1'b1};
                end
                else
                begin
                    rem_next = div_sh[63:0];
                    q_next   = {q_reg[16:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd1)
                    state_next = S_UPDATE;
            end

            S_UPDATE:
            begin
                if (upd_tc[PW-1:0] == t_reg)
                    state_next = S_FINISH;
                else
                begin
                    t_next = upd_tc[PW-1:0];
                    if (steps_reg < SW'(MAX_ITER))
                    begin
                        steps_next = steps_reg + SW'(1);
                        mstep_next = '0;
                        state_next = S_EVAL;
                    end
                    else
                        state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.refined_param  = t_reg;
                    result_next.coarse_index   = 7'(search_start_reg);
                    result_next.steps_used     = 5'(steps_reg);
                    result_next.flat_curvature = flat_reg;
                    result_valid_next          = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            c0x_reg          <= '0;
            c0y_reg          <= '0;
            c1x_reg          <= '0;
            c1y_reg          <= '0;
            c2x_reg          <= '0;
            c2y_reg          <= '0;
            result_valid_reg <= 1'b0;
            search_start_reg <= '0;
            start_q_reg      <= '0;
            start_r_reg      <= IW'(RINIT);
            building_reg     <= 1'b0;
            mstep_reg        <= '0;
            iss_active_reg   <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            steps_reg        <= '0;
            flat_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            c0x_reg          <= c0x_next;
            c0y_reg          <= c0y_next;
            c1x_reg          <= c1x_next;
            c1y_reg          <= c1y_next;
            c2x_reg          <= c2x_next;
            c2y_reg          <= c2y_next;
            result_valid_reg <= result_valid_next;
            search_start_reg <= search_start_next;
            start_q_reg      <= start_q_next;
            start_r_reg      <= start_r_next;
            building_reg     <= building_next;
            mstep_reg        <= mstep_next;
            iss_active_reg   <= iss_active_next;
            v1_reg           <= v1_next;
            v2_reg           <= v2_next;
            v3_reg           <= v3_next;
            steps_reg        <= steps_next;
            flat_reg         <= flat_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        t_reg        <= t_next;
        idx_reg      <= idx_next;
        acc_q_reg    <= acc_q_next;
        acc_r_reg    <= acc_r_next;
        first_reg    <= first_next;
        prod_reg     <= mul_a * mul_b;
        for (int j = 0; j < 7; j++)
            pr_reg[j] <= pr_next[j];
        for (int j = 0; j < 6; j++)
        begin
            vv_reg[j] <= vv_next[j];
            vs_reg[j] <= vs_next[j];
        end
        f1_reg       <= f1_next;
        f2_reg       <= f2_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
        dcnt_reg     <= dcnt_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        idx1_reg     <= idx1_next;
        idx2_reg     <= idx2_next;
        idx3_reg     <= idx3_next;
        q1_reg       <= q1_next;
        q2_reg       <= q2_next;
        q3_reg       <= q3_next;
        r1_reg       <= r1_next;
        r2_reg       <= r2_next;
        r3_reg       <= r3_next;
        fs1_reg      <= fs1_next;
        fs2_reg      <= fs2_next;
        fs3_reg      <= fs3_next;
        dx2_reg      <= dx2_next;
        dy2_reg      <= dy2_next;
        sqx3_reg     <= sqx3_next;
        sqy3_reg     <= sqy3_next;
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        best_q_reg   <= best_q_next;
        best_r_reg   <= best_r_next;
    end

    // ports
    assign point_ready  = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready |=> !point_ready)
        else $error("second point taken while one is in flight");

    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.refined_param <= 17'(bfpn_pkg::ONE_Q16))
        else $error("refined parameter beyond 1.0");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= SW'(MAX_ITER))
        else $error("Newton step count past limit");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPDATE |-> q_reg <= 18'(bfpn_pkg::STEP_SAT))
        else $error("Newton step larger than saturation");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadratic Bezier foot point finder. Points are
// pushed through the valid/ready input under random gaps and output stalls.
// Each accepted point is projected by a behavioral model of the coarse sample
// search and the Newton refinement, and each result beat is compared field by
// field with the oldest prediction. The curve is reprogrammed between phases,
// extremes and degenerate curves included.
// ----------------------------------------------------------------------------
module testbench;

    import bfpn_pkg::*;

    localparam int  NSAMP     = SAMPLES_DEF;
    localparam int  NITER     = MAX_ITER_DEF;
    localparam int  N_PHASES  = 12;
    localparam int  PHASE_LEN = 86;
    localparam int  HOLD_LEN  = 400;
    localparam longint LIMIT  = 8000000;
    localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S_MIN = 32'sh80000000;

    logic        clk;
    logic        rst_n;
    logic        point_valid;
    logic        point_ready;
    point_t      point;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    bezier_foot_point_newton i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // model state: control points, sample table, search start
    int        ctl_x [3];
    int        ctl_y [3];
    int        samp_x [NSAMP];
    int        samp_y [NSAMP];
    int        scan_from;

    result_t   pending_feet [$];
    int        mismatches;
    longint    cycles;
    bit        quiet;
    bit        hold_req;

    // directed table
    typedef struct {
        point_t  pt;
        bit      new_curve;   // drain and load the demo curve first
        bit      known;
        result_t want;
    } row_t;
    row_t      rows [$];

    // ------------------------------------------------------------------
    // Behavioral model
    // ------------------------------------------------------------------
    function automatic longint rnd16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint curve_pt(longint c0, longint c1, longint c2, longint t);
        longint a, b, t2, r;
        a  = c1 - c0;
        b  = c0 - 2 * c1 + c2;
        t2 = rnd16(t * t);
        r  = c0 + rnd16(2 * t * a + t2 * b);
        if (r > longint'(S_MAX)) r = S_MAX;
        if (r < longint'(S_MIN)) r = S_MIN;
        return r;
    endfunction

    function automatic longint slope_pt(longint c0, longint c1, longint c2, longint t);
        return 2 * (c1 - c0) + rnd16(2 * t * (c0 - 2 * c1 + c2));
    endfunction

    function automatic longint sample_param(int i);
        return longint'((i * 65536 + (NSAMP - 1) / 2) / (NSAMP - 1));
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic result_t project_point(point_t p);
        longint px, py, t, lo, hi, f1, f2, tn, m, num, den, q;
        longint v [6];
        longint unsigned dd, best_d, dx, dy;
        int best, steps, k;
        bit flat;
        result_t r;
        px = p.point_x;
        py = p.point_y;
        flat = 0;
        steps = 0;
        best_d = 0;
        // rebuild the sample table at the start of a set
        if (p.first_of_set) begin
            for (int i = 0; i < NSAMP; i++) begin
                samp_x[i] = int'(curve_pt(ctl_x[0], ctl_x[1], ctl_x[2], sample_param(i)));
                samp_y[i] = int'(curve_pt(ctl_y[0], ctl_y[1], ctl_y[2], sample_param(i)));
            end
            scan_from = 0;
        end
        if (scan_from >= NSAMP) scan_from = 0;
        // forward scan, first strict minimum
        best = scan_from;
        for (int i = scan_from; i < NSAMP; i++) begin
            dx = longint'(absl(longint'(samp_x[i]) - px)) >> 1;
            dy = longint'(absl(longint'(samp_y[i]) - py)) >> 1;
            dd = dx * dx + dy * dy;
            if (i == scan_from || dd < best_d) begin
                best_d = dd;
                best = i;
            end
        end
        scan_from = best;
        t  = sample_param(best);
        lo = (t - WIN_HALF < 0) ? 0 : t - WIN_HALF;
        hi = (t + WIN_HALF > ONE_Q16) ? ONE_Q16 : t + WIN_HALF;
        // Newton refinement inside the window
        while (steps < NITER) begin
            steps++;
            v[0] = curve_pt(ctl_x[0], ctl_x[1], ctl_x[2], t) - px;
            v[1] = curve_pt(ctl_y[0], ctl_y[1], ctl_y[2], t) - py;
            v[2] = slope_pt(ctl_x[0], ctl_x[1], ctl_x[2], t);
            v[3] = slope_pt(ctl_y[0], ctl_y[1], ctl_y[2], t);
            v[4] = 2 * (longint'(ctl_x[0]) - 2 * longint'(ctl_x[1]) + longint'(ctl_x[2]));
            v[5] = 2 * (longint'(ctl_y[0]) - 2 * longint'(ctl_y[1]) + longint'(ctl_y[2]));
            m = 0;
            for (int j = 0; j < 6; j++) if (absl(v[j]) > m) m = absl(v[j]);
            k = 0;
            while ((m >>> k) >= (longint'(1) << 30)) k++;
            for (int j = 0; j < 6; j++) v[j] = v[j] >>> k;
            f1 = v[0] * v[2] + v[1] * v[3];
            f2 = v[2] * v[2] + v[3] * v[3] + v[0] * v[4] + v[1] * v[5];
            if (f2 == 0) begin
                flat = 1;
                break;
            end
            num = absl(f1);
            den = absl(f2);
            if (num >= 2 * den) begin
                q = STEP_SAT;
            end
            else begin
                q = 0;
                if (num >= den) begin q = 1; num -= den; end
                for (int j = 0; j < 16; j++) begin
                    num = num << 1;
                    q = q << 1;
                    if (num >= den) begin q |= 1; num -= den; end
                end
            end
            tn = ((f1 < 0) != (f2 < 0)) ? t + q : t - q;
            if (tn < lo) tn = lo;
            else if (tn > hi) tn = hi;
            if (tn == t) break;
            t = tn;
        end
        r.refined_param  = t[16:0];
        r.coarse_index   = best[6:0];
        r.steps_used     = steps[4:0];
        r.flat_curvature = flat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("** bezier_foot_point_newton: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 0;
            end
            else
                result_ready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    // result check; the beat is taken at the next rising edge
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_feet.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", result);
            end
            else
            begin
                want = pending_feet.pop_front();
                if (result.refined_param !== want.refined_param
                    || result.coarse_index !== want.coarse_index
                    || result.steps_used !== want.steps_used
                    || result.flat_curvature !== want.flat_curvature)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp param %0d idx %0d steps %0d flat %0d, got param %0d idx %0d steps %0d flat %0d",
                            want.refined_param, want.coarse_index, want.steps_used,
                            want.flat_curvature, result.refined_param, result.coarse_index,
                            result.steps_used, result.flat_curvature);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        case (idx)
            REG_CTRL0_X: ctl_x[0] = val;
            REG_CTRL0_Y: ctl_y[0] = val;
            REG_CTRL1_X: ctl_x[1] = val;
            REG_CTRL1_Y: ctl_y[1] = val;
            REG_CTRL2_X: ctl_x[2] = val;
            REG_CTRL2_Y: ctl_y[2] = val;
            default: ;
        endcase
    endtask

    task automatic load_curve(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                              logic [31:0] y1, logic [31:0] x2, logic [31:0] y2);
        cfg_write(REG_CTRL0_X, x0);
        cfg_write(REG_CTRL0_Y, y0);
        cfg_write(REG_CTRL1_X, x1);
        cfg_write(REG_CTRL1_Y, y1);
        cfg_write(REG_CTRL2_X, x2);
        cfg_write(REG_CTRL2_Y, y2);
        cfg_valid <= 0;
    endtask

    // valid may already be high from the previous beat
    task automatic send_point(point_t p, bit known, result_t want);
        result_t pred;
        if (!quiet && $urandom_range(99) < 7)
        begin
            point_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        point <= p;
        point_valid <= 1;
        @(negedge clk);
        while (!point_ready) @(negedge clk);
        @(posedge clk);
        pred = project_point(p);
        pending_feet.push_back(known ? want : pred);
    endtask

    task automatic drain();
        point_valid <= 0;
        while (pending_feet.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic point_t mk_point(logic [31:0] x, logic [31:0] y, bit f);
        point_t p;
        p.point_x = x;
        p.point_y = y;
        p.first_of_set = f;
        return p;
    endfunction

    function automatic void add_row(logic [31:0] x, logic [31:0] y, bit f, bit nc, bit known);
        row_t r;
        r.pt = mk_point(x, y, f);
        r.new_curve = nc;
        r.known = known;
        // zero curve: every point sees a flat second derivative at sample zero
        r.want.refined_param = '0;
        r.want.coarse_index = '0;
        r.want.steps_used = 5'd1;
        r.want.flat_curvature = 1'b1;
        rows.push_back(r);
    endfunction

    // random control coordinate for one kind of curve
    function automatic logic [31:0] rand_coord(int kind);
        case (kind)
            0: return $urandom_range(0, 32'h00c8_0000) - 32'h0064_0000;
            1: return ($urandom_range(1)) ? S_MAX : S_MIN;
            2: return $urandom();
            default: return $urandom_range(0, 32) - 16;
        endcase
    endfunction

    // point near the curve, or anywhere
    function automatic point_t near_point(bit f);
        longint t, x, y;
        int sel;
        t = $urandom_range(0, ONE_Q16);
        x = curve_pt(ctl_x[0], ctl_x[1], ctl_x[2], t);
        y = curve_pt(ctl_y[0], ctl_y[1], ctl_y[2], t);
        sel = $urandom_range(9);
        if (sel < 5)
        begin
            x += int'($urandom_range(0, 8192)) - 4096;
            y += int'($urandom_range(0, 8192)) - 4096;
        end
        else if (sel < 8)
        begin
            x += int'($urandom_range(0, 2097152)) - 1048576;
            y += int'($urandom_range(0, 2097152)) - 1048576;
        end
        else
        begin
            x = $urandom();
            y = $urandom();
        end
        return mk_point(x[31:0], y[31:0], f);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        result_t none;
        int kind;
        logic [31:0] c [6];
        none = '0;
        rst_n = 0;
        point_valid = 0;
        point = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 0;
        hold_req = 0;
        mismatches = 0;
        cycles = 0;
        scan_from = 0;
        for (int i = 0; i < 3; i++) begin ctl_x[i] = 0; ctl_y[i] = 0; end
        for (int i = 0; i < NSAMP; i++) begin samp_x[i] = 0; samp_y[i] = 0; end
        repeat (12) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // zero curve after reset, field extremes
        add_row(32'h0, 32'h0, 1, 0, 1);
        add_row(S_MAX, S_MAX, 0, 0, 1);
        add_row(S_MIN, S_MIN, 0, 0, 1);
        add_row(S_MAX, S_MIN, 0, 0, 1);
        add_row(S_MIN, S_MAX, 1, 0, 1);
        add_row(32'h1234_5678, 32'hffff_ffff, 0, 0, 1);
        // arch (0,0) (2,4) (4,0): ends, apex, beyond ends, backward point
        add_row(32'h0, 32'h0, 1, 1, 0);
        add_row(32'h0001_0000, 32'h0001_8000, 0, 0, 0);
        add_row(32'h0002_0000, 32'h0002_0000, 0, 0, 0);
        add_row(32'h0004_0000, 32'h0, 0, 0, 0);
        add_row(32'h0, 32'h0, 0, 0, 0);
        add_row(32'h0008_0000, 32'hfffc_0000, 0, 0, 0);
        add_row(32'hfff8_0000, 32'hfffc_0000, 1, 0, 0);
        add_row(32'h0002_0000, 32'h0100_0000, 0, 0, 0);
        add_row(S_MAX, S_MAX, 1, 0, 0);
        add_row(S_MIN, S_MIN, 1, 0, 0);
        add_row(32'h0003_0000, 32'h0001_8000, 0, 0, 0);
        add_row(32'h0000_8000, 32'h0000_c000, 1, 0, 0);
        foreach (rows[i])
        begin
            if (rows[i].new_curve)
            begin
                drain();
                load_curve(32'h0, 32'h0, 32'h0002_0000, 32'h0004_0000, 32'h0004_0000, 32'h0);
            end
            send_point(rows[i].pt, rows[i].known, rows[i].want);
        end

        // random phases, each with its own curve
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            kind = ph % 4;
            for (int j = 0; j < 6; j++) c[j] = rand_coord(kind);
            if (ph == 6)
            begin
                // straight line: zero curvature term
                c[2] = c[0] + 2 * ($urandom_range(0, 32'h0040_0000));
                c[4] = 2 * c[2] - c[0];
                c[3] = c[1];
                c[5] = c[1];
            end
            load_curve(c[0], c[1], c[2], c[3], c[4], c[5]);
            quiet = (ph == 3);
            if (ph == 5) hold_req = 1;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (n == PHASE_LEN / 2 && (ph % 3) == 1)
                begin
                    // mid-set curve change: old samples, new Newton curve
                    drain();
                    for (int j = 0; j < 6; j++) c[j] = rand_coord(kind);
                    load_curve(c[0], c[1], c[2], c[3], c[4], c[5]);
                end
                if (n == PHASE_LEN / 3 && ph == 8) drain();
                if ($urandom_range(14) == 0)
                    send_point(mk_point($urandom(), $urandom(), $urandom_range(1)), 0, none);
                else
                    send_point(near_point(n == 0 || $urandom_range(11) == 0), 0, none);
            end
        end
        quiet = 0;

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("** bezier_foot_point_newton: PASSED **");
        else
            $display("** bezier_foot_point_newton: FAILED **");
        $finish;
    end

endmodule

### sim.f
hw/rtl/bfpn_pkg.sv
hw/rtl/bfpn_ram.sv
hw/rtl/bezier_foot_point_newton.sv
tb/testbench.sv
